// File: src/assert_macros.svh
// Assertion macros shared by the breakpoint and watchpoint unit modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BWU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BWU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bwu_pkg.sv
// Types and constants shared by the breakpoint and watchpoint unit.
package bwu_pkg;

  localparam int NUM_BREAKPOINTS = 8;
  localparam int NUM_READ_WATCH  = 8;
  localparam int NUM_WRITE_WATCH = 8;

  localparam int FUNC_W   = 4;
  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 17;
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_PC_CHECK   = 4'd0,
    FN_RD_CHECK   = 4'd1,
    FN_WR_CHECK   = 4'd2,
    FN_BP_ADD     = 4'd3,
    FN_BP_REMOVE  = 4'd4,
    FN_RW_ADD     = 4'd5,
    FN_RW_REMOVE  = 4'd6,
    FN_WW_ADD     = 4'd7,
    FN_WW_REMOVE  = 4'd8,
    FN_DETACH     = 4'd9,
    FN_RESUME     = 4'd10,
    FN_STEP       = 4'd11
  } func_t;

  typedef enum logic [1:0] {
    MODE_RUN   = 2'd0,
    MODE_BREAK = 2'd1,
    MODE_PRE   = 2'd2,
    MODE_POST  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    EV_NONE  = 2'd0,
    EV_BREAK = 2'd1,
    EV_READ  = 2'd2,
    EV_WRITE = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_EXEC = 2'd1,
    CS_DONE = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

// File: src/bwu_req_if.sv
// Request channel of the breakpoint and watchpoint unit.
interface bwu_req_if;
  logic                        valid;
  logic                        ready;
  logic [bwu_pkg::FUNC_W-1:0]  func;
  logic [bwu_pkg::ADDR_W-1:0]  addr;
  logic [bwu_pkg::LEN_W-1:0]   length;

  modport source (output valid, output func, output addr, output length, input ready);
  modport sink (input valid, input func, input addr, input length, output ready);
endinterface

// File: src/bwu_rsp_if.sv
// Response channel of the breakpoint and watchpoint unit.
interface bwu_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bwu_pkg::STATUS_W-1:0]  status;
  logic                          stop;
  logic [bwu_pkg::KIND_W-1:0]    event_kind;
  logic [bwu_pkg::ADDR_W-1:0]    event_addr;

  modport source (output valid, output status, output stop, output event_kind,
                  output event_addr, input ready);
  modport sink (input valid, input status, input stop, input event_kind,
                input event_addr, output ready);
endinterface

// File: src/bwu_ctrl.sv
// Controller state machine that sequences capture, execution and delivery of a beat.
`include "assert_macros.svh"

module bwu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output bwu_pkg::ctrl_cmd_t  cmd
);

  bwu_pkg::ctrl_state_t state;
  bwu_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bwu_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      bwu_pkg::CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = bwu_pkg::CS_EXEC;
        end
      end
      bwu_pkg::CS_EXEC: begin
        cmd.execute = 1'b1;
        state_next  = bwu_pkg::CS_DONE;
      end
      bwu_pkg::CS_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = bwu_pkg::CS_IDLE;
        end
      end
      default: begin
        state_next = bwu_pkg::CS_IDLE;
      end
    endcase
  end

  `BWU_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state == bwu_pkg::CS_EXEC, "accepted beat not executed")
  `BWU_ASSERT_NEXT(a_exec_deliver, cmd.execute, out_valid, "executed beat not presented")
  `BWU_ASSERT_IMPL(a_one_in_flight, out_valid, !in_ready, "new beat taken while result pending")

endmodule

// File: src/bwu_datapath.sv
// Datapath holding the breakpoint and watch tables, the run mode and the result register.
`include "assert_macros.svh"

module bwu_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  bwu_pkg::ctrl_cmd_t             cmd,
  input  logic [bwu_pkg::FUNC_W-1:0]     func,
  input  logic [bwu_pkg::ADDR_W-1:0]     addr,
  input  logic [bwu_pkg::LEN_W-1:0]      length,
  output logic [bwu_pkg::STATUS_W-1:0]   status,
  output logic                           stop,
  output logic [bwu_pkg::KIND_W-1:0]     event_kind,
  output logic [bwu_pkg::ADDR_W-1:0]     event_addr
);

  localparam int NB = bwu_pkg::NUM_BREAKPOINTS;
  localparam int NR = bwu_pkg::NUM_READ_WATCH;
  localparam int NW = bwu_pkg::NUM_WRITE_WATCH;
  localparam int AW = bwu_pkg::ADDR_W;
  localparam int LW = bwu_pkg::LEN_W;

  bwu_pkg::func_t  func_q;
  logic [AW-1:0]   addr_q;
  logic [LW-1:0]   len_q;
  logic [AW-1:0]   aend_q;

  logic [AW-1:0]   bp_address [NB];
  logic [NB-1:0]   bp_valid;
  logic [AW-1:0]   rw_start [NR];
  logic [LW-1:0]   rw_len [NR];
  logic [AW-1:0]   rw_end [NR];
  logic [NR-1:0]   rw_valid;
  logic [AW-1:0]   ww_start [NW];
  logic [LW-1:0]   ww_len [NW];
  logic [AW-1:0]   ww_end [NW];
  logic [NW-1:0]   ww_valid;

  bwu_pkg::mode_t  run_mode;
  logic            watch_pending;
  logic            pending_is_read;
  logic [AW-1:0]   pending_addr;

  bwu_pkg::status_t status_q;
  logic             stop_q;
  bwu_pkg::event_t  kind_q;
  logic [AW-1:0]    eaddr_q;

  logic [NB-1:0] bp_hit;
  logic [NB-1:0] bp_del;
  logic [NB-1:0] bp_free;
  logic [NR-1:0] rw_hit;
  logic [NR-1:0] rw_del;
  logic [NR-1:0] rw_free;
  logic [NW-1:0] ww_hit;
  logic [NW-1:0] ww_del;
  logic [NW-1:0] ww_free;

  function automatic logic overlap(input logic [AW-1:0] a0, input logic [AW-1:0] a1,
                                   input logic [AW-1:0] w0, input logic [AW-1:0] w1);
    overlap = (a0 >= w0 && a0 <= w1) || (a1 >= w0 && a1 <= w1) ||
              (w0 >= a0 && w0 <= a1) || (w1 >= a0 && w1 <= a1);
  endfunction

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      bp_hit[i] = bp_valid[i] && (bp_address[i] == addr_q);
    end
    for (int i = 0; i < NR; i++) begin
      rw_hit[i] = rw_valid[i] && overlap(addr_q, aend_q, rw_start[i], rw_end[i]);
      rw_del[i] = rw_valid[i] && (rw_start[i] == addr_q) && (rw_len[i] == len_q);
    end
    for (int i = 0; i < NW; i++) begin
      ww_hit[i] = ww_valid[i] && overlap(addr_q, aend_q, ww_start[i], ww_end[i]);
      ww_del[i] = ww_valid[i] && (ww_start[i] == addr_q) && (ww_len[i] == len_q);
    end
  end

  // Lowest clear valid bit and lowest matching entry, each as a one-hot vector.
  assign bp_free = ~bp_valid & (bp_valid + NB'(1));
  assign rw_free = ~rw_valid & (rw_valid + NR'(1));
  assign ww_free = ~ww_valid & (ww_valid + NW'(1));
  assign bp_del  = bp_hit & (~bp_hit + NB'(1));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= bwu_pkg::func_t'(func);
      addr_q <= addr;
      len_q  <= length;
      aend_q <= addr + AW'(length) - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int i = 0; i < NB; i++) begin
        if (func_q == bwu_pkg::FN_BP_ADD && bp_free[i]) begin
          bp_address[i] <= addr_q;
        end
      end
      for (int i = 0; i < NR; i++) begin
        if (func_q == bwu_pkg::FN_RW_ADD && rw_free[i]) begin
          rw_start[i] <= addr_q;
          rw_len[i]   <= len_q;
          rw_end[i]   <= aend_q;
        end
      end
      for (int i = 0; i < NW; i++) begin
        if (func_q == bwu_pkg::FN_WW_ADD && ww_free[i]) begin
          ww_start[i] <= addr_q;
          ww_len[i]   <= len_q;
          ww_end[i]   <= aend_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bp_valid        <= '0;
      rw_valid        <= '0;
      ww_valid        <= '0;
      run_mode        <= bwu_pkg::MODE_BREAK;
      watch_pending   <= 1'b0;
      pending_is_read <= 1'b0;
      pending_addr    <= '0;
    end else if (cmd.execute) begin
      status_q <= bwu_pkg::ST_OK;
      stop_q   <= 1'b0;
      kind_q   <= bwu_pkg::EV_NONE;
      eaddr_q  <= '0;
      case (func_q)
        bwu_pkg::FN_PC_CHECK: begin
          if (run_mode == bwu_pkg::MODE_BREAK) begin
            stop_q <= 1'b1;
          end else if (run_mode == bwu_pkg::MODE_POST) begin
            run_mode <= bwu_pkg::MODE_BREAK;
            stop_q   <= 1'b1;
            kind_q   <= bwu_pkg::EV_BREAK;
          end else if (run_mode == bwu_pkg::MODE_PRE) begin
            run_mode <= bwu_pkg::MODE_POST;
          end else if (watch_pending) begin
            kind_q        <= pending_is_read ? bwu_pkg::EV_READ : bwu_pkg::EV_WRITE;
            eaddr_q       <= pending_addr;
            watch_pending <= 1'b0;
            run_mode      <= bwu_pkg::MODE_BREAK;
            stop_q        <= 1'b1;
          end else if (|bp_hit) begin
            run_mode <= bwu_pkg::MODE_BREAK;
            stop_q   <= 1'b1;
            kind_q   <= bwu_pkg::EV_BREAK;
          end
        end
        bwu_pkg::FN_RD_CHECK: begin
          if (run_mode == bwu_pkg::MODE_RUN && |rw_hit) begin
            watch_pending   <= 1'b1;
            pending_addr    <= addr_q;
            pending_is_read <= 1'b1;
            stop_q          <= 1'b1;
          end
        end
        bwu_pkg::FN_WR_CHECK: begin
          if (run_mode == bwu_pkg::MODE_RUN && |ww_hit) begin
            watch_pending   <= 1'b1;
            pending_addr    <= addr_q;
            pending_is_read <= 1'b0;
            stop_q          <= 1'b1;
          end
        end
        bwu_pkg::FN_BP_ADD: begin
          bp_valid <= bp_valid | bp_free;
          if (bp_free == '0) begin
            status_q <= bwu_pkg::ST_FULL;
          end
        end
        bwu_pkg::FN_BP_REMOVE: begin
          bp_valid <= bp_valid & ~bp_del;
          if (bp_del == '0) begin
            status_q <= bwu_pkg::ST_MISSING;
          end
        end
        bwu_pkg::FN_RW_ADD: begin
          rw_valid <= rw_valid | rw_free;
          if (rw_free == '0) begin
            status_q <= bwu_pkg::ST_FULL;
          end
        end
        bwu_pkg::FN_RW_REMOVE: begin
          rw_valid <= rw_valid & ~(rw_del & (~rw_del + NR'(1)));
          if (rw_del == '0) begin
            status_q <= bwu_pkg::ST_MISSING;
          end
        end
        bwu_pkg::FN_WW_ADD: begin
          ww_valid <= ww_valid | ww_free;
          if (ww_free == '0) begin
            status_q <= bwu_pkg::ST_FULL;
          end
        end
        bwu_pkg::FN_WW_REMOVE: begin
          ww_valid <= ww_valid & ~(ww_del & (~ww_del + NW'(1)));
          if (ww_del == '0) begin
            status_q <= bwu_pkg::ST_MISSING;
          end
        end
        bwu_pkg::FN_DETACH: begin
          bp_valid <= '0;
        end
        bwu_pkg::FN_RESUME: begin
          run_mode <= bwu_pkg::MODE_RUN;
        end
        bwu_pkg::FN_STEP: begin
          run_mode <= bwu_pkg::MODE_PRE;
        end
        default: begin
        end
      endcase
    end
  end

  assign status     = status_q;
  assign stop       = stop_q;
  assign event_kind = kind_q;
  assign event_addr = eaddr_q;

  `BWU_ASSERT_NEXT(a_halted_stops, cmd.execute && func_q == bwu_pkg::FN_PC_CHECK && run_mode == bwu_pkg::MODE_BREAK, stop_q && run_mode == bwu_pkg::MODE_BREAK, "pc check in break did not hold")
  `BWU_ASSERT_NEXT(a_idle_access, cmd.execute && (func_q == bwu_pkg::FN_RD_CHECK || func_q == bwu_pkg::FN_WR_CHECK) && run_mode != bwu_pkg::MODE_RUN, !stop_q && $stable(watch_pending), "access check acted while not running")

endmodule

// File: src/breakpoint_watchpoint_unit.sv
// Top level of the breakpoint and watchpoint unit.
// The req channel carries one command beat: func selects a pc check, a read or write
// access check, adding or removing a breakpoint or a read or write watch range, detach,
// resume or single step; addr and length give the address and byte count.
// Every request beat yields exactly one beat on the rsp channel with status, stop,
// event_kind and event_addr.
// An accepted beat is captured in the idle state, executed against all table entries in
// parallel in the exec state, and presented on rsp in the done state.
// One beat is in flight at a time: no new beat is taken until the last result has gone
// out through the capture, execute and deliver steps of the controller.
// While rsp is stalled, the result holds steady and req stays not ready.
// Reset clears all table valid bits and any pending watch hit, and puts the unit in
// the halted mode; the unit is ready for a beat as soon as reset is released.
module breakpoint_watchpoint_unit (
  input  logic       clk,
  input  logic       rst,
  bwu_req_if.sink    req,
  bwu_rsp_if.source  rsp
);

  bwu_pkg::ctrl_cmd_t cmd;

  bwu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  bwu_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .func       (req.func),
    .addr       (req.addr),
    .length     (req.length),
    .status     (rsp.status),
    .stop       (rsp.stop),
    .event_kind (rsp.event_kind),
    .event_addr (rsp.event_addr)
  );

endmodule

// File: test/tb.sv
// Self-checking testbench for the breakpoint and watchpoint unit with its own predictor.
`timescale 1ns / 1ps

module tb;

  localparam int TAB_BP = 0;
  localparam int TAB_RW = 1;
  localparam int TAB_WW = 2;
  localparam int TAB_SLOTS = 64;
  localparam int RANDOM_ITEMS = 1870;
  localparam int DRAIN_CYCLES = 5000;
  localparam int TIMEOUT_NS = 5_000_000;
  localparam logic [3:0] FN_UNUSED_LO = 4'd12;
  localparam logic [3:0] FN_UNUSED_HI = 4'd15;
  localparam logic [16:0] LEN_FULL = 17'h10000;
  localparam logic [16:0] LEN_MAX = 17'h1FFFF;
  localparam logic [31:0] CODE_BASE = 32'h0000_1000;
  localparam logic [31:0] DATA_BASE = 32'h8000_0000;

  typedef struct {
    bwu_pkg::status_t status;
    logic             stop;
    bwu_pkg::event_t  kind;
    logic [31:0]      addr;
  } rsp_beat_t;

  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_BURSTY} ready_style_t;

  logic clk;
  logic rst;

  bwu_req_if req ();
  bwu_rsp_if rsp ();

  breakpoint_watchpoint_unit DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  bwu_pkg::mode_t pred_mode = bwu_pkg::MODE_BREAK;
  bit          pend_valid = 1'b0;
  bit          pend_read = 1'b0;
  logic [31:0] pend_addr = '0;
  logic [31:0] tab_start [3][TAB_SLOTS];
  logic [16:0] tab_len [3][TAB_SLOTS];
  bit          tab_used [3][TAB_SLOTS];

  rsp_beat_t expected_rsp_q [$];

  int mismatch_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int break_stops = 0;
  int watch_reports = 0;
  int full_replies = 0;
  int missing_replies = 0;
  int burst_left = 0;

  ready_style_t ready_style = RDY_ALWAYS;
  int style_left = 40;
  int stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d beats still expected", expected_rsp_q.size());
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch in %s at beat %0d: got %h, expected %h", what, checked_count, got, want);
    mismatch_count++;
  endtask

  function automatic int table_depth(int t);
    case (t)
      TAB_BP: return bwu_pkg::NUM_BREAKPOINTS;
      TAB_RW: return bwu_pkg::NUM_READ_WATCH;
      default: return bwu_pkg::NUM_WRITE_WATCH;
    endcase
  endfunction

  function automatic logic [3:0] table_cmd(int t, bit remove);
    case (t)
      TAB_BP: return remove ? bwu_pkg::FN_BP_REMOVE : bwu_pkg::FN_BP_ADD;
      TAB_RW: return remove ? bwu_pkg::FN_RW_REMOVE : bwu_pkg::FN_RW_ADD;
      default: return remove ? bwu_pkg::FN_WW_REMOVE : bwu_pkg::FN_WW_ADD;
    endcase
  endfunction

  function automatic bit spans_overlap(logic [31:0] a0, logic [16:0] alen,
                                       logic [31:0] w0, logic [16:0] wlen);
    logic [31:0] a1;
    logic [31:0] w1;
    a1 = a0 + {15'd0, alen} - 32'd1;
    w1 = w0 + {15'd0, wlen} - 32'd1;
    return (a0 >= w0 && a0 <= w1) || (a1 >= w0 && a1 <= w1) ||
           (w0 >= a0 && w0 <= a1) || (w1 >= a0 && w1 <= a1);
  endfunction

  function automatic int slot_lookup(int t, logic [31:0] a, logic [16:0] len);
    for (int i = 0; i < table_depth(t); i++) begin
      if (tab_used[t][i] && tab_start[t][i] == a && (t == TAB_BP || tab_len[t][i] == len))
        return i;
    end
    return -1;
  endfunction

  function automatic bwu_pkg::status_t slot_insert(int t, logic [31:0] a, logic [16:0] len);
    for (int i = 0; i < table_depth(t); i++) begin
      if (!tab_used[t][i]) begin
        tab_start[t][i] = a;
        tab_len[t][i] = len;
        tab_used[t][i] = 1'b1;
        return bwu_pkg::ST_OK;
      end
    end
    full_replies++;
    return bwu_pkg::ST_FULL;
  endfunction

  function automatic bwu_pkg::status_t slot_remove(int t, logic [31:0] a, logic [16:0] len);
    int slot;
    slot = slot_lookup(t, a, len);
    if (slot < 0) begin
      missing_replies++;
      return bwu_pkg::ST_MISSING;
    end
    tab_used[t][slot] = 1'b0;
    return bwu_pkg::ST_OK;
  endfunction

  function automatic logic access_watch(int t, logic [31:0] a, logic [16:0] len, bit is_read);
    if (pred_mode != bwu_pkg::MODE_RUN)
      return 1'b0;
    for (int i = 0; i < table_depth(t); i++) begin
      if (tab_used[t][i] && spans_overlap(a, len, tab_start[t][i], tab_len[t][i])) begin
        pend_valid = 1'b1;
        pend_addr = a;
        pend_read = is_read;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic rsp_beat_t predict_response(logic [3:0] code, logic [31:0] a,
                                                 logic [16:0] len);
    rsp_beat_t r;
    r.status = bwu_pkg::ST_OK;
    r.stop = 1'b0;
    r.kind = bwu_pkg::EV_NONE;
    r.addr = '0;
    case (code)
      bwu_pkg::FN_PC_CHECK: begin
        if (pred_mode == bwu_pkg::MODE_BREAK) begin
          r.stop = 1'b1;
        end else if (pred_mode == bwu_pkg::MODE_POST) begin
          pred_mode = bwu_pkg::MODE_BREAK;
          r.stop = 1'b1;
          r.kind = bwu_pkg::EV_BREAK;
        end else if (pred_mode == bwu_pkg::MODE_PRE) begin
          pred_mode = bwu_pkg::MODE_POST;
        end else if (pend_valid) begin
          r.kind = pend_read ? bwu_pkg::EV_READ : bwu_pkg::EV_WRITE;
          r.addr = pend_addr;
          pend_valid = 1'b0;
          pred_mode = bwu_pkg::MODE_BREAK;
          r.stop = 1'b1;
        end else if (slot_lookup(TAB_BP, a, len) >= 0) begin
          pred_mode = bwu_pkg::MODE_BREAK;
          r.stop = 1'b1;
          r.kind = bwu_pkg::EV_BREAK;
        end
      end
      bwu_pkg::FN_RD_CHECK: r.stop = access_watch(TAB_RW, a, len, 1'b1);
      bwu_pkg::FN_WR_CHECK: r.stop = access_watch(TAB_WW, a, len, 1'b0);
      bwu_pkg::FN_BP_ADD: r.status = slot_insert(TAB_BP, a, len);
      bwu_pkg::FN_BP_REMOVE: r.status = slot_remove(TAB_BP, a, len);
      bwu_pkg::FN_RW_ADD: r.status = slot_insert(TAB_RW, a, len);
      bwu_pkg::FN_RW_REMOVE: r.status = slot_remove(TAB_RW, a, len);
      bwu_pkg::FN_WW_ADD: r.status = slot_insert(TAB_WW, a, len);
      bwu_pkg::FN_WW_REMOVE: r.status = slot_remove(TAB_WW, a, len);
      bwu_pkg::FN_DETACH: begin
        for (int i = 0; i < bwu_pkg::NUM_BREAKPOINTS; i++)
          tab_used[TAB_BP][i] = 1'b0;
      end
      bwu_pkg::FN_RESUME: pred_mode = bwu_pkg::MODE_RUN;
      bwu_pkg::FN_STEP: pred_mode = bwu_pkg::MODE_PRE;
      default: ;
    endcase
    if (r.kind == bwu_pkg::EV_BREAK)
      break_stops++;
    else if (r.kind != bwu_pkg::EV_NONE)
      watch_reports++;
    return r;
  endfunction

  // The sender runs in bursts; a gap lowers valid at the edge that took the last beat.
  task automatic send_beat(logic [3:0] code, logic [31:0] a, logic [16:0] len);
    int gap;
    req.valid <= 1'b1;
    req.func <= code;
    req.addr <= a;
    req.length <= len;
    do @(posedge clk); while (req.ready !== 1'b1);
    expected_rsp_q.push_back(predict_response(code, a, len));
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(0, 40);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin : rsp_check
    rsp_beat_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("unexpected beat", rsp.event_addr, '0);
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
        if (rsp.stop !== want.stop)
          report_mismatch("stop", 32'(rsp.stop), 32'(want.stop));
        if (rsp.event_kind !== want.kind)
          report_mismatch("event_kind", 32'(rsp.event_kind), 32'(want.kind));
        if (rsp.event_addr !== want.addr)
          report_mismatch("event_addr", rsp.event_addr, want.addr);
      end
      checked_count++;
    end
    if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left--;
    end else begin
      case (ready_style)
        RDY_ALWAYS: rsp.ready <= 1'b1;
        RDY_COIN: rsp.ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 12);
            rsp.ready <= 1'b0;
          end else begin
            rsp.ready <= 1'b1;
          end
        end
      endcase
    end
    if (style_left == 0) begin
      ready_style = ready_style_t'($urandom_range(0, 2));
      style_left = $urandom_range(30, 200);
    end else begin
      style_left--;
    end
  end

  function automatic logic [16:0] random_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 17'($urandom_range(1, 16));
    if (roll < 78) return 17'd0;
    if (roll < 90) return 17'($urandom);
    if (roll < 95) return LEN_FULL;
    return LEN_MAX;
  endfunction

  function automatic logic [31:0] fresh_addr();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return $urandom;
    if (roll < 8) return CODE_BASE + 32'(4 * $urandom_range(0, 15));
    return 32'hFFFF_FFFF - 32'($urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] near_watch(int t);
    int slot;
    slot = $urandom_range(0, table_depth(t) - 1);
    if (tab_used[t][slot])
      return tab_start[t][slot] + 32'($urandom_range(0, 40)) - 32'd20;
    return fresh_addr();
  endfunction

  function automatic logic [31:0] pc_target();
    int slot;
    slot = $urandom_range(0, bwu_pkg::NUM_BREAKPOINTS - 1);
    if ($urandom_range(0, 9) < 4 && tab_used[TAB_BP][slot])
      return tab_start[TAB_BP][slot];
    return fresh_addr();
  endfunction

  task automatic test_table_commands();
    send_beat(bwu_pkg::FN_PC_CHECK, 32'h0, 17'd1);
    send_beat(bwu_pkg::FN_RD_CHECK, 32'h0, 17'd1);
    send_beat(bwu_pkg::FN_BP_ADD, 32'hFFFF_FFFF, 17'd0);
    send_beat(bwu_pkg::FN_BP_REMOVE, 32'h1234_5678, 17'd0);
    send_beat(bwu_pkg::FN_RW_ADD, 32'hFFFF_FFF0, 17'h20);
    send_beat(bwu_pkg::FN_RW_REMOVE, 32'hFFFF_FFF0, 17'h21);
    send_beat(bwu_pkg::FN_WW_ADD, CODE_BASE, 17'd0);
    send_beat(bwu_pkg::FN_WW_ADD, 32'h0, LEN_MAX);
    // Six more adds fill the write table and the seventh finds no free entry.
    for (int i = 0; i < 7; i++)
      send_beat(bwu_pkg::FN_WW_ADD, DATA_BASE + 32'(i * 256), 17'd16);
  endtask

  task automatic test_run_control();
    send_beat(bwu_pkg::FN_RESUME, 32'h0, 17'd0);
    send_beat(bwu_pkg::FN_RD_CHECK, 32'h5, 17'd1);
    send_beat(bwu_pkg::FN_WR_CHECK, 32'h0001_FFFE, 17'd1);
    send_beat(bwu_pkg::FN_PC_CHECK, 32'hFFFF_FFFF, 17'd0);
    send_beat(bwu_pkg::FN_STEP, 32'h0, 17'd0);
    send_beat(bwu_pkg::FN_PC_CHECK, 32'h0, 17'd0);
    send_beat(bwu_pkg::FN_PC_CHECK, 32'h4, 17'd0);
    send_beat(bwu_pkg::FN_RESUME, 32'h0, 17'd0);
    send_beat(bwu_pkg::FN_PC_CHECK, 32'hFFFF_FFFF, 17'd0);
    send_beat(bwu_pkg::FN_DETACH, 32'h0, 17'd0);
    send_beat(bwu_pkg::FN_RESUME, 32'h0, 17'd0);
    send_beat(bwu_pkg::FN_PC_CHECK, 32'hFFFF_FFFF, 17'd0);
    send_beat(FN_UNUSED_LO, 32'hFFFF_FFFF, LEN_MAX);
    send_beat(FN_UNUSED_HI, 32'hFFFF_FFFF, LEN_MAX);
  endtask

  task automatic test_random_traffic();
    int pick;
    int t;
    int slot;
    logic [3:0] code;
    logic [31:0] a;
    logic [16:0] len;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      len = random_length();
      a = fresh_addr();
      if (pick < 30) begin
        code = bwu_pkg::FN_PC_CHECK;
        a = pc_target();
      end else if (pick < 42) begin
        code = bwu_pkg::FN_RD_CHECK;
        a = near_watch(TAB_RW);
      end else if (pick < 54) begin
        code = bwu_pkg::FN_WR_CHECK;
        a = near_watch(TAB_WW);
      end else if (pick < 66) begin
        code = table_cmd($urandom_range(0, 2), 1'b0);
      end else if (pick < 76) begin
        t = $urandom_range(0, 2);
        slot = $urandom_range(0, table_depth(t) - 1);
        code = table_cmd(t, 1'b1);
        if (tab_used[t][slot] && $urandom_range(0, 3) != 0) begin
          a = tab_start[t][slot];
          len = tab_len[t][slot];
        end
      end else if (pick < 78) begin
        code = bwu_pkg::FN_DETACH;
      end else if (pick < 90) begin
        code = bwu_pkg::FN_RESUME;
      end else if (pick < 97) begin
        code = bwu_pkg::FN_STEP;
      end else begin
        code = 4'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
      end
      send_beat(code, a, len);
    end
  endtask

  initial begin
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.func <= '0;
    req.addr <= '0;
    req.length <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_table_commands();
    test_run_control();
    test_random_traffic();
    req.valid <= 1'b0;
    for (int i = 0; i < DRAIN_CYCLES && expected_rsp_q.size() != 0; i++)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_rsp_q.size() != 0)
      report_mismatch("missing beats", '0, 32'(expected_rsp_q.size()));
    $display("sent %0d commands and checked %0d beats: %0d break stops, %0d watch reports",
             sent_count, checked_count, break_stops, watch_reports);
    $display("table replies seen: %0d with no free entry, %0d with no matching entry",
             full_replies, missing_replies);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
